### hw/rtl/sqlesc_pkg.sv
// ----------------------------------------------------------------------------
// sqlesc_pkg: shared types and constants of the byte escaper
// Request payloads, configuration registers, queue entries and the table of
// special bytes with their second characters.
// ----------------------------------------------------------------------------
package sqlesc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned PADDR_W         = 4;
  localparam int unsigned PDATA_W         = 32;

  localparam logic [7:0] SQL_BACKSLASH = 8'd92;
  localparam logic [7:0] SUB_BYTE      = 8'd26;
  localparam logic [7:0] NUL_BYTE      = 8'd0;
  localparam logic [7:0] LF_BYTE       = 8'd10;
  localparam logic [7:0] CR_BYTE       = 8'd13;
  localparam logic [7:0] SQUOTE_BYTE   = 8'd39;
  localparam logic [7:0] DQUOTE_BYTE   = 8'd34;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_N        = 8'h6E;
  localparam logic [7:0] CHAR_R        = 8'h72;
  localparam logic [7:0] CHAR_Z        = 8'h5A;
  localparam logic [7:0] NO_SECOND     = 8'd0;

  localparam logic       ESCAPE_MODE_RST     = 1'b0;
  localparam logic [7:0] ESCAPE_CHAR_RST     = 8'd92;
  localparam logic [7:0] TERMINATOR_CHAR_RST = 8'd9;

  typedef enum logic [1:0] {
    REG_ESCAPE_MODE     = 2'd0,
    REG_ESCAPE_CHAR     = 2'd1,
    REG_TERMINATOR_CHAR = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_SQL       = 1'b0,
    MODE_LOAD_DATA = 1'b1
  } escape_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_done;
    logic       stream_done;
  } out_item_t;

  typedef struct packed {
    logic       escape_mode;
    logic [7:0] escape_char;
    logic [7:0] terminator_char;
  } cfg_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            stream_end;
  } work_t;

  function automatic logic [7:0] second_char(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      NUL_BYTE:      s = CHAR_ZERO;
      LF_BYTE:       s = CHAR_N;
      CR_BYTE:       s = CHAR_R;
      SUB_BYTE:      s = CHAR_Z;
      SQUOTE_BYTE:   s = SQUOTE_BYTE;
      DQUOTE_BYTE:   s = DQUOTE_BYTE;
      SQL_BACKSLASH: s = SQL_BACKSLASH;
      default:       s = NO_SECOND;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/sql_load_data_byte_escaper.sv
// ----------------------------------------------------------------------------
// sql_load_data_byte_escaper: escapes text field bytes for SQL or load data
// Each request on the input channel carries one source byte and a flag for
// the last byte of the field. The output channel carries one escaped byte
// per request, flagged on the last byte of each source byte and of the field.
// An APB-style port holds the mode, the escape byte and the terminator byte;
// they are to be written only while no request is in flight; the user is
// bound by this, as the block does not enforce it. An accepted byte passes
// through a queue slot and then the output register. Throughput: one input
// request per cycle while each expands to one byte and out_stall is low. The
// output register moves one byte per cycle unless stalled. A four-entry queue
// between intake and output absorbs bursts of special bytes; in_stall rises
// only when that queue is full.
// When the receiver stalls, the output byte holds and the queue fills, then
// in_stall rises.
// Reset empties the queue, drops out_valid and loads the register defaults:
// SQL mode, escape byte backslash, terminator tab.
// ----------------------------------------------------------------------------
module sql_load_data_byte_escaper #(
  parameter int unsigned QUEUE_DEPTH = sqlesc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sqlesc_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sqlesc_pkg::out_item_t             out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sqlesc_pkg::PADDR_W-1:0]    paddr,
  input  logic [sqlesc_pkg::PDATA_W-1:0]    pwdata,
  output logic [sqlesc_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);
  import sqlesc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  work_t    entry;
  work_t    head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ESCAPE_MODE:     cfg_nxt.escape_mode     = pwdata[0];
        REG_ESCAPE_CHAR:     cfg_nxt.escape_char     = pwdata[7:0];
        REG_TERMINATOR_CHAR: cfg_nxt.terminator_char = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ESCAPE_MODE:     prdata = {{(PDATA_W-1){1'b0}}, cfg_r.escape_mode};
      REG_ESCAPE_CHAR:     prdata = {{(PDATA_W-8){1'b0}}, cfg_r.escape_char};
      REG_TERMINATOR_CHAR: prdata = {{(PDATA_W-8){1'b0}}, cfg_r.terminator_char};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_mode     <= ESCAPE_MODE_RST;
      cfg_r.escape_char     <= ESCAPE_CHAR_RST;
      cfg_r.terminator_char <= TERMINATOR_CHAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sqlesc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  sqlesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  sqlesc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/sqlesc_front.sv
// ----------------------------------------------------------------------------
// sqlesc_front: request intake and classification
// Accepts source bytes, expands each into its one to four escaped bytes and
// pushes the result into the work queue.
// ----------------------------------------------------------------------------
module sqlesc_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  sqlesc_pkg::in_item_t in_data,
  input  sqlesc_pkg::cfg_t    cfg,
  input  logic                q_full,
  output logic                push,
  output sqlesc_pkg::work_t   entry
);
  import sqlesc_pkg::*;

  logic [7:0] sec;
  logic [7:0] sec2;
  logic       special;
  logic [2:0] n;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign sec      = second_char(in_data.in_byte);
  assign special  = (sec != NO_SECOND);
  assign sec2     = (sec == SQL_BACKSLASH) ? cfg.escape_char : sec;

  always_comb begin
    entry            = '0;
    entry.stream_end = in_data.stream_end;
    n                = 3'd0;
    if (cfg.escape_mode == MODE_SQL) begin
      if (special) begin
        entry.bytes[n[1:0]] = SQL_BACKSLASH;
        n = n + 3'd1;
        entry.bytes[n[1:0]] = sec;
        n = n + 3'd1;
      end else begin
        entry.bytes[n[1:0]] = in_data.in_byte;
        n = n + 3'd1;
      end
    end else begin
      if (special) begin
        if (cfg.escape_char == cfg.terminator_char) begin
          entry.bytes[n[1:0]] = cfg.escape_char;
          n = n + 3'd1;
        end
        entry.bytes[n[1:0]] = cfg.escape_char;
        n = n + 3'd1;
        if (sec2 == cfg.terminator_char) begin
          entry.bytes[n[1:0]] = cfg.escape_char;
          n = n + 3'd1;
        end
        entry.bytes[n[1:0]] = sec2;
        n = n + 3'd1;
      end else begin
        if (in_data.in_byte == cfg.terminator_char) begin
          entry.bytes[n[1:0]] = cfg.escape_char;
          n = n + 3'd1;
        end
        entry.bytes[n[1:0]] = in_data.in_byte;
        n = n + 3'd1;
      end
    end
    entry.last_idx = 2'(n - 3'd1);
  end

endmodule

### hw/rtl/sqlesc_queue.sv
// ----------------------------------------------------------------------------
// sqlesc_queue: work queue between intake and output
// A small first-in first-out queue of expanded entries with full and empty.
// ----------------------------------------------------------------------------
module sqlesc_queue #(
  parameter int unsigned DEPTH = sqlesc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sqlesc_pkg::work_t din,
  input  logic              pop,
  output sqlesc_pkg::work_t dout,
  output logic              full,
  output logic              empty
);
  import sqlesc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t             slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

endmodule

### hw/rtl/sqlesc_back.sv
// ----------------------------------------------------------------------------
// sqlesc_back: output serializer
// Walks the head entry of the work queue into the output register one byte
// per cycle while the output is not stalled; pops it as its last byte loads.
// ----------------------------------------------------------------------------
module sqlesc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sqlesc_pkg::work_t     head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sqlesc_pkg::out_item_t out_data
);
  import sqlesc_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic       last;

  assign load = !q_empty && (!out_valid_r || !out_stall);
  assign last = (idx_r == head.last_idx);
  assign pop  = load && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      idx_nxt                  = last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = head.bytes[idx_r];
      out_data_nxt.item_done   = last;
      out_data_nxt.stream_done = last && head.stream_end;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/sqlesc_checker.sv
// ----------------------------------------------------------------------------
// sqlesc_checker: port-level checks of the byte escaper
// Watches the output channel and the register port of the top level.
// ----------------------------------------------------------------------------
module sqlesc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input sqlesc_pkg::out_item_t out_data,
  input logic                  pready
);
  import sqlesc_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output request dropped");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled output request changed");

  a_stream_done_on_item_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_done |-> out_data.item_done)
    else $error("field end flagged before the last byte of its source byte");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("output valid after reset");

endmodule

bind sql_load_data_byte_escaper sqlesc_checker u_sqlesc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
